// File: hdl/mesch_pkg.sv
package mesch_pkg;

    // Sizes of the event queue and the note table.
    localparam int QUEUE_DEPTH = 32;
    localparam int NOTE_COUNT  = 128;
    localparam int NOTE_W      = $clog2(NOTE_COUNT);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 15;

    // Register addresses.
    localparam logic [2:0] ADDR_BYPASS = 3'd0;

    // Input opcodes.
    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_TIMER   = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    // Kinds of queued entries.
    localparam logic [1:0] EK_NOTE_ON  = 2'd0;
    localparam logic [1:0] EK_NOTE_OFF = 2'd1;
    localparam logic [1:0] EK_CTRL     = 2'd2;
    localparam logic [1:0] EK_TIMER    = 2'd3;

    // Result kinds.
    localparam logic [2:0] R_NOTE_ON  = 3'd0;
    localparam logic [2:0] R_NOTE_OFF = 3'd1;
    localparam logic [2:0] R_CTRL     = 3'd2;
    localparam logic [2:0] R_TIMER    = 3'd3;
    localparam logic [2:0] R_ACCEPT   = 3'd4;
    localparam logic [2:0] R_FULL     = 3'd5;
    localparam logic [2:0] R_DONE     = 3'd6;

    localparam logic [ID_W-1:0] ID_MAX = 15'h7FFF;

    typedef struct packed {
        logic [1:0]      kind;
        logic [ID_W-1:0] ctl;
        logic [15:0]     val;
        logic [15:0]     cd;
    } qentry_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  kind;
        logic [6:0]  ctl;
        logic [15:0] val;
        logic [15:0] amt;
    } cmd_t;

    typedef struct packed {
        logic [2:0]      kind;
        logic [ID_W-1:0] ctl;
        logic [15:0]     val;
        logic [ID_W-1:0] obj;
        logic            last;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             busy;
    } status_t;

    // Wrapping id counter step: ids run from one up to one below the maximum.
    function automatic logic [ID_W-1:0] next_id(input logic [ID_W-1:0] cur);
        logic [ID_W-1:0] n;
        n = cur + 15'd1;
        if (n == ID_MAX || n == 15'd0)
        begin
            n = 15'd1;
        end
        return n;
    endfunction

endpackage

// File: hdl/mesch_front.sv
module mesch_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  logic [1:0]          opcode,
    input  logic [1:0]          event_kind,
    input  logic [6:0]          control,
    input  logic [15:0]         value,
    input  logic [15:0]         time_amount,
    output mesch_pkg::cmd_t     q_cmd,
    output logic                q_valid,
    input  logic                q_pop
);

    mesch_pkg::cmd_t slot_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      fill_reg, fill_next;
    logic            push;
    logic            accept;

    // A transaction is taken whenever the two-entry queue has room.
    assign cmd_ready = (fill_reg != 2'd2);
    assign accept    = cmd_valid && cmd_ready;
    // Unknown opcodes are accepted and dropped here, as they cause no result.
    assign push      = accept && (opcode != mesch_pkg::OP_NONE);
    assign q_valid   = (fill_reg != 2'd0);
    assign q_cmd     = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Payload storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{op: opcode, kind: event_kind, ctl: control,
                                      val: value, amt: time_amount};
        end
    end

endmodule

// File: hdl/mesch_back.sv
module mesch_back (
    input  logic                clk,
    input  logic                rst_n,
    input  mesch_pkg::cmd_t     q_cmd,
    input  logic                q_valid,
    output logic                q_pop,
    input  logic                bypass,
    output mesch_pkg::result_t  res,
    output logic                res_valid,
    input  logic                res_ready,
    output mesch_pkg::status_t  status
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DRAIN = 2'd1;
    localparam logic [1:0] S_NOTE  = 2'd2;

    mesch_pkg::qentry_t entries_reg [mesch_pkg::QUEUE_DEPTH];
    mesch_pkg::qentry_t ins_next    [mesch_pkg::QUEUE_DEPTH];
    mesch_pkg::qentry_t pop_next    [mesch_pkg::QUEUE_DEPTH];
    mesch_pkg::qentry_t dec_next    [mesch_pkg::QUEUE_DEPTH];
    logic [mesch_pkg::QUEUE_DEPTH-1:0] stays_ahead;

    logic [1:0]                   state_reg, state_next;
    logic [mesch_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [mesch_pkg::ID_W-1:0]   note_ctr_reg, note_ctr_next;
    logic [mesch_pkg::ID_W-1:0]   timer_ctr_reg, timer_ctr_next;
    logic [mesch_pkg::NOTE_COUNT-1:0] note_valid_reg, note_valid_next;
    logic [mesch_pkg::ID_W-1:0]   note_mem [mesch_pkg::NOTE_COUNT];
    logic [mesch_pkg::ID_W-1:0]   note_rd_reg;
    mesch_pkg::result_t           res_reg, res_new;
    logic                         res_valid_reg, res_valid_next;

    mesch_pkg::qentry_t           new_e;
    mesch_pkg::qentry_t           head;
    logic [mesch_pkg::NOTE_W-1:0] hnote;
    logic [mesch_pkg::ID_W-1:0]   new_id;
    logic                         slot_free;
    logic                         emit, do_ins, do_pop, do_dec;
    logic                         note_rd_en, note_wr_en;

    assign head      = entries_reg[0];
    assign hnote     = head.ctl[mesch_pkg::NOTE_W-1:0];
    assign slot_free = !res_valid_reg || res_ready;
    assign res       = res_reg;
    assign res_valid = res_valid_reg;
    assign status    = '{count: count_reg, busy: (state_reg != S_IDLE)};

    // Per-entry cells: sorted insert, head removal and countdown decrement.
    for (genvar i = 0; i < mesch_pkg::QUEUE_DEPTH; i++)
    begin : g_cell
        assign stays_ahead[i] = (mesch_pkg::CNT_W'(i) < count_reg) &&
                                ((entries_reg[i].cd < q_cmd.amt) ||
                                 ((entries_reg[i].cd == q_cmd.amt) &&
                                  (entries_reg[i].kind == mesch_pkg::EK_CTRL)));
        if (i == 0)
        begin : g_first
            assign ins_next[i] = stays_ahead[i] ? entries_reg[i] : new_e;
        end
        else
        begin : g_rest
            assign ins_next[i] = stays_ahead[i] ? entries_reg[i] :
                                 (stays_ahead[i-1] ? new_e : entries_reg[i-1]);
        end
        if (i == mesch_pkg::QUEUE_DEPTH - 1)
        begin : g_tail
            assign pop_next[i] = entries_reg[i];
        end
        else
        begin : g_body
            assign pop_next[i] = entries_reg[i+1];
        end
        assign dec_next[i] = '{kind: entries_reg[i].kind, ctl: entries_reg[i].ctl,
                               val: entries_reg[i].val,
                               cd: entries_reg[i].cd - q_cmd.amt};
    end

    // Sequencer for the command at the head of the front queue.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        note_ctr_next   = note_ctr_reg;
        timer_ctr_next  = timer_ctr_reg;
        note_valid_next = note_valid_reg;
        q_pop           = 1'b0;
        emit            = 1'b0;
        do_ins          = 1'b0;
        do_pop          = 1'b0;
        do_dec          = 1'b0;
        note_rd_en      = 1'b0;
        note_wr_en      = 1'b0;
        res_new         = '0;
        new_id          = mesch_pkg::next_id(note_ctr_reg);
        new_e           = '{kind: q_cmd.kind, ctl: {8'd0, q_cmd.ctl},
                            val: q_cmd.val, cd: q_cmd.amt};

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    unique case (q_cmd.op)
                        mesch_pkg::OP_INSERT, mesch_pkg::OP_TIMER:
                        begin
                            q_pop       = 1'b1;
                            emit        = 1'b1;
                            res_new.last = 1'b1;
                            if (count_reg >= mesch_pkg::CNT_W'(mesch_pkg::QUEUE_DEPTH))
                            begin
                                res_new.kind = mesch_pkg::R_FULL;
                            end
                            else if (q_cmd.op == mesch_pkg::OP_TIMER)
                            begin
                                timer_ctr_next = mesch_pkg::next_id(timer_ctr_reg);
                                new_e = '{kind: mesch_pkg::EK_TIMER, ctl: timer_ctr_next,
                                          val: q_cmd.val, cd: q_cmd.amt};
                                do_ins       = 1'b1;
                                res_new.kind = mesch_pkg::R_ACCEPT;
                                res_new.ctl  = timer_ctr_next;
                            end
                            else
                            begin
                                do_ins       = (q_cmd.kind != mesch_pkg::EK_TIMER);
                                res_new.kind = mesch_pkg::R_ACCEPT;
                            end
                        end
                        mesch_pkg::OP_ADVANCE:
                        begin
                            if (bypass)
                            begin
                                q_pop        = 1'b1;
                                emit         = 1'b1;
                                res_new.kind = mesch_pkg::R_DONE;
                                res_new.last = 1'b1;
                            end
                            else
                            begin
                                state_next = S_DRAIN;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_DRAIN:
            begin
                if ((count_reg != '0) && (head.cd <= q_cmd.amt))
                begin
                    note_rd_en = 1'b1;
                    state_next = S_NOTE;
                end
                else if (slot_free)
                begin
                    do_dec       = 1'b1;
                    q_pop        = 1'b1;
                    emit         = 1'b1;
                    res_new.kind = mesch_pkg::R_DONE;
                    res_new.last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_NOTE:
            begin
                if (slot_free)
                begin
                    do_pop      = 1'b1;
                    state_next  = S_DRAIN;
                    res_new.ctl = head.ctl;
                    res_new.val = head.val;
                    unique case (head.kind)
                        mesch_pkg::EK_NOTE_ON:
                        begin
                            if (!note_valid_reg[hnote])
                            begin
                                note_ctr_next          = new_id;
                                note_valid_next[hnote] = 1'b1;
                                note_wr_en             = 1'b1;
                                emit                   = 1'b1;
                                res_new.kind           = mesch_pkg::R_NOTE_ON;
                                res_new.obj            = new_id;
                            end
                        end
                        mesch_pkg::EK_NOTE_OFF:
                        begin
                            if (note_valid_reg[hnote])
                            begin
                                note_valid_next[hnote] = 1'b0;
                                emit                   = 1'b1;
                                res_new.kind           = mesch_pkg::R_NOTE_OFF;
                                res_new.obj            = note_rd_reg;
                            end
                        end
                        mesch_pkg::EK_CTRL:
                        begin
                            emit         = 1'b1;
                            res_new.kind = mesch_pkg::R_CTRL;
                        end
                        default:
                        begin
                            emit         = 1'b1;
                            res_new.kind = mesch_pkg::R_TIMER;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        count_next = count_reg + mesch_pkg::CNT_W'(do_ins) - mesch_pkg::CNT_W'(do_pop);
        res_valid_next = emit ? 1'b1 : (res_ready ? 1'b0 : res_valid_reg);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            note_ctr_reg   <= '0;
            timer_ctr_reg  <= '0;
            note_valid_reg <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            note_ctr_reg   <= note_ctr_next;
            timer_ctr_reg  <= timer_ctr_next;
            note_valid_reg <= note_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Queue cells and the result register.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < mesch_pkg::QUEUE_DEPTH; i++)
        begin
            if (do_ins)
            begin
                entries_reg[i] <= ins_next[i];
            end
            else if (do_pop)
            begin
                entries_reg[i] <= pop_next[i];
            end
            else if (do_dec)
            begin
                entries_reg[i] <= dec_next[i];
            end
        end
        if (emit)
        begin
            res_reg <= res_new;
        end
    end

    // Note id memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (note_wr_en)
        begin
            note_mem[hnote] <= new_id;
        end
        if (note_rd_en)
        begin
            note_rd_reg <= note_mem[hnote];
        end
    end

endmodule

// File: hdl/midi_event_scheduler_with_note_ids_core.sv
// MIDI event scheduler: items enter through a two-entry command queue and are
// executed one at a time. An insert or timer request is answered straight from the
// idle state (the sorted insert is done by all queue cells at once); an advance
// enters the drain state, reads the note id memory and then handles each due
// event, and ends with the advance done result, while a bypassed advance gets
// its done result straight from the idle state. A stalled result holds the
// executor until it is taken. The register bypass at address 0 may only be
// written while idle.
module midi_event_scheduler_with_note_ids_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic [1:0]  opcode,
    input  logic [1:0]  event_kind,
    input  logic [6:0]  control,
    input  logic [15:0] value,
    input  logic [15:0] time_amount,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [2:0]  result_kind,
    output logic [14:0] control_res,
    output logic [15:0] value_res,
    output logic [14:0] object_id,
    output logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    mesch_pkg::cmd_t    q_cmd;
    logic               q_valid;
    logic               q_pop;
    mesch_pkg::result_t res;
    mesch_pkg::status_t status;
    logic               bypass_reg, bypass_next;

    // Register port: single bypass register.
    assign pready      = 1'b1;
    assign prdata      = {31'd0, bypass_reg};
    assign bypass_next = (psel && penable && pwrite && (paddr == mesch_pkg::ADDR_BYPASS)) ?
                         pwdata[0] : bypass_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg <= 1'b0;
        end
        else
        begin
            bypass_reg <= bypass_next;
        end
    end

    mesch_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .opcode      (opcode),
        .event_kind  (event_kind),
        .control     (control),
        .value       (value),
        .time_amount (time_amount),
        .q_cmd       (q_cmd),
        .q_valid     (q_valid),
        .q_pop       (q_pop)
    );

    mesch_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_cmd     (q_cmd),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .bypass    (bypass_reg),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .status    (status)
    );

    assign result_kind = res.kind;
    assign control_res = res.ctl;
    assign value_res   = res.val;
    assign object_id   = res.obj;
    assign last        = res.last;

    // The queue never holds more entries than it has cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.count <= mesch_pkg::CNT_W'(mesch_pkg::QUEUE_DEPTH))
        else $error("event queue count exceeds depth");

    // The fill count moves by at most one entry per cycle.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (status.count == $past(status.count)) ||
                 (status.count == $past(status.count) + mesch_pkg::CNT_W'(1)) ||
                 (status.count == $past(status.count) - mesch_pkg::CNT_W'(1)))
        else $error("event queue count jumped");

    // Advance done, accepted and queue full always close their transaction.
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && ((result_kind == mesch_pkg::R_DONE) ||
                      (result_kind == mesch_pkg::R_ACCEPT) ||
                      (result_kind == mesch_pkg::R_FULL)) |-> last)
        else $error("closing result without last");

endmodule

// File: sim/tb.sv
module tb;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    logic [1:0]  opcode = mesch_pkg::OP_INSERT;
    logic [1:0]  event_kind = mesch_pkg::EK_NOTE_ON;
    logic [6:0]  control = '0;
    logic [15:0] value = '0;
    logic [15:0] time_amount = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [2:0]  result_kind;
    logic [14:0] control_res;
    logic [15:0] value_res;
    logic [14:0] object_id;
    logic        last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    localparam int WATCHDOG_LIMIT = 20000;

    midi_event_scheduler_with_note_ids_core dut (.*);

    always #6 clk = ~clk;

    // Scheduler model state.
    mesch_pkg::qentry_t         sched_q[$];
    logic [mesch_pkg::ID_W-1:0] note_ids[mesch_pkg::NOTE_COUNT];
    logic [mesch_pkg::ID_W-1:0] note_ctr;
    logic [mesch_pkg::ID_W-1:0] timer_ctr;
    logic                       bypass_mode;

    mesch_pkg::cmd_t    pending_cmds[$];
    mesch_pkg::result_t expected_results[$];
    int      error_count = 0;
    int      idle_cycles = 0;
    logic    cmd_taken = 1'b0;

    function automatic logic [mesch_pkg::ID_W-1:0] bump_id(
        inout logic [mesch_pkg::ID_W-1:0] ctr);
        logic [mesch_pkg::ID_W-1:0] n;
        n = ctr + 1'b1;
        if (n == mesch_pkg::ID_MAX || n == '0)
        begin
            n = mesch_pkg::ID_W'(1);
        end
        ctr = n;
        return n;
    endfunction

    function automatic void push_result(logic [2:0] k, logic [mesch_pkg::ID_W-1:0] c,
                                        logic [15:0] v, logic [mesch_pkg::ID_W-1:0] o,
                                        logic l);
        mesch_pkg::result_t r;
        r.kind = k;
        r.ctl  = c;
        r.val  = v;
        r.obj  = o;
        r.last = l;
        expected_results = {expected_results, r};
    endfunction

    // Sorted insert: ahead of the first later-or-equal entry, after equal-time controllers.
    function automatic void schedule_entry(logic [1:0] k, logic [mesch_pkg::ID_W-1:0] c,
                                           logic [15:0] v, logic [15:0] cd);
        int                 p;
        mesch_pkg::qentry_t e;
        p = 0;
        while (p < sched_q.size() && sched_q[p].cd < cd)
        begin
            p++;
        end
        while (p < sched_q.size() && sched_q[p].cd == cd &&
               sched_q[p].kind == mesch_pkg::EK_CTRL)
        begin
            p++;
        end
        e.kind = k;
        e.ctl  = c;
        e.val  = v;
        e.cd   = cd;
        sched_q.insert(p, e);
    endfunction

    // Works out the results that one accepted command causes.
    function automatic void predict_schedule(mesch_pkg::cmd_t c);
        mesch_pkg::qentry_t         e;
        logic [mesch_pkg::ID_W-1:0] id;
        int                         note;
        if (c.op == mesch_pkg::OP_INSERT || c.op == mesch_pkg::OP_TIMER)
        begin
            if (sched_q.size() >= mesch_pkg::QUEUE_DEPTH)
            begin
                push_result(mesch_pkg::R_FULL, '0, '0, '0, 1'b1);
            end
            else if (c.op == mesch_pkg::OP_TIMER)
            begin
                id = bump_id(timer_ctr);
                schedule_entry(mesch_pkg::EK_TIMER, id, c.val, c.amt);
                push_result(mesch_pkg::R_ACCEPT, id, '0, '0, 1'b1);
            end
            else
            begin
                if (c.kind != mesch_pkg::EK_TIMER)
                begin
                    schedule_entry(c.kind, mesch_pkg::ID_W'(c.ctl), c.val, c.amt);
                end
                push_result(mesch_pkg::R_ACCEPT, '0, '0, '0, 1'b1);
            end
        end
        else if (c.op == mesch_pkg::OP_ADVANCE)
        begin
            if (!bypass_mode)
            begin
                while (sched_q.size() > 0 && sched_q[0].cd <= c.amt)
                begin
                    e = sched_q[0];
                    sched_q.delete(0);
                    note = int'(e.ctl[mesch_pkg::NOTE_W-1:0]);
                    if (e.kind == mesch_pkg::EK_NOTE_ON)
                    begin
                        if (note_ids[note] == '0)
                        begin
                            note_ids[note] = bump_id(note_ctr);
                            push_result(mesch_pkg::R_NOTE_ON, e.ctl, e.val,
                                        note_ids[note], 1'b0);
                        end
                    end
                    else if (e.kind == mesch_pkg::EK_NOTE_OFF)
                    begin
                        if (note_ids[note] != '0)
                        begin
                            push_result(mesch_pkg::R_NOTE_OFF, e.ctl, e.val,
                                        note_ids[note], 1'b0);
                            note_ids[note] = '0;
                        end
                    end
                    else if (e.kind == mesch_pkg::EK_CTRL)
                    begin
                        push_result(mesch_pkg::R_CTRL, e.ctl, e.val, '0, 1'b0);
                    end
                    else
                    begin
                        push_result(mesch_pkg::R_TIMER, e.ctl, e.val, '0, 1'b0);
                    end
                end
                foreach (sched_q[i])
                begin
                    sched_q[i].cd = sched_q[i].cd - c.amt;
                end
            end
            push_result(mesch_pkg::R_DONE, '0, '0, '0, 1'b1);
        end
    endfunction

    function automatic mesch_pkg::cmd_t make_cmd(logic [1:0] op, logic [1:0] k,
                                                 logic [6:0] ctl, logic [15:0] v,
                                                 logic [15:0] amt);
        mesch_pkg::cmd_t c;
        c.op   = op;
        c.kind = k;
        c.ctl  = ctl;
        c.val  = v;
        c.amt  = amt;
        return c;
    endfunction

    function automatic void queue_cmd(mesch_pkg::cmd_t c);
        pending_cmds = {pending_cmds, c};
    endfunction

    // Mostly well-formed note events and controllers on low notes, timers and advances with small delays.
    function automatic mesch_pkg::cmd_t random_cmd();
        int sel;
        logic [15:0] amt;
        sel = $urandom_range(0, 99);
        amt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
        if (sel < 45)
            return make_cmd(mesch_pkg::OP_INSERT, 2'($urandom_range(0, 2)),
                            7'($urandom_range(0, 7)), 16'($urandom), amt);
        else if (sel < 52)
            return make_cmd(mesch_pkg::OP_INSERT, 2'($urandom), 7'($urandom),
                            16'($urandom), amt);
        else if (sel < 65)
            return make_cmd(mesch_pkg::OP_TIMER, 2'($urandom), 7'($urandom),
                            16'($urandom), amt);
        else if (sel < 97)
            return make_cmd(mesch_pkg::OP_ADVANCE, 2'($urandom), 7'($urandom),
                            16'($urandom), amt);
        return make_cmd(mesch_pkg::OP_NONE, 2'($urandom), 7'($urandom), 16'($urandom),
                        16'($urandom));
    endfunction

    // Driver: bursts and gaps, one transaction per handshake.
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge clk)
    begin
        mesch_pkg::cmd_t c;
        if (rst_n)
        begin
            if (cmd_valid && !cmd_taken)
            begin
                // Hold the payload until the transaction is accepted.
            end
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                cmd_valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                c = pending_cmds[0];
                pending_cmds.delete(0);
                cmd_valid   <= 1'b1;
                opcode      <= c.op;
                event_kind  <= c.kind;
                control     <= c.ctl;
                value       <= c.val;
                time_amount <= c.amt;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                cmd_valid <= 1'b0;
            end
            // Receiver stall pattern: long ready runs broken by short stalls.
            res_ready <= ($urandom_range(0, 15) < 11);
        end
    end

    // Monitor: predict on accepted commands, check accepted results.
    always @(posedge clk)
    begin
        mesch_pkg::result_t exp_r;
        if (rst_n)
        begin
            cmd_taken <= cmd_valid && cmd_ready;
            if (cmd_valid && cmd_ready)
            begin
                predict_schedule(make_cmd(opcode, event_kind, control, value, time_amount));
            end
            if (res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result kind=%0d", result_kind);
                    error_count++;
                end
                else
                begin
                    exp_r = expected_results[0];
                    expected_results.delete(0);
                    if (result_kind !== exp_r.kind)
                    begin
                        $error("result_kind expected %0d actual %0d", exp_r.kind, result_kind);
                        error_count++;
                    end
                    if (control_res !== exp_r.ctl)
                    begin
                        $error("control_res expected %0d actual %0d", exp_r.ctl, control_res);
                        error_count++;
                    end
                    if (value_res !== exp_r.val)
                    begin
                        $error("value_res expected %0d actual %0d", exp_r.val, value_res);
                        error_count++;
                    end
                    if (object_id !== exp_r.obj)
                    begin
                        $error("object_id expected %0d actual %0d", exp_r.obj, object_id);
                        error_count++;
                    end
                    if (last !== exp_r.last)
                    begin
                        $error("last expected %0d actual %0d", exp_r.last, last);
                        error_count++;
                    end
                end
            end
            // Watchdog on cycles without any transaction.
            if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("DONE: errors detected");
                    $finish;
                end
            end
        end
    end

    task automatic wait_idle();
        while (pending_cmds.size() > 0 || cmd_valid || expected_results.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic write_bypass(logic v);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= mesch_pkg::ADDR_BYPASS;
        pwdata <= {31'd0, v};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        bypass_mode = v;
    endtask

    task automatic add_random(int n);
        repeat (n)
        begin
            queue_cmd(random_cmd());
        end
    endtask

    initial
    begin
        sched_q.delete();
        foreach (note_ids[i])
        begin
            note_ids[i] = '0;
        end
        note_ctr = '0;
        timer_ctr = '0;
        bypass_mode = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, every operation, duplicates, bad kind, equal times.
        queue_cmd(make_cmd(mesch_pkg::OP_INSERT, mesch_pkg::EK_NOTE_ON, 7'd127, 16'hFFFF,
                           16'd5));
        queue_cmd(make_cmd(mesch_pkg::OP_INSERT, mesch_pkg::EK_NOTE_ON, 7'd127, 16'd1, 16'd5));
        queue_cmd(make_cmd(mesch_pkg::OP_INSERT, mesch_pkg::EK_CTRL, 7'd0, 16'd0, 16'd5));
        queue_cmd(make_cmd(mesch_pkg::OP_INSERT, mesch_pkg::EK_CTRL, 7'd7, 16'h8000, 16'd5));
        queue_cmd(make_cmd(mesch_pkg::OP_INSERT, mesch_pkg::EK_NOTE_OFF, 7'd3, 16'd9, 16'd0));
        queue_cmd(make_cmd(mesch_pkg::OP_INSERT, mesch_pkg::EK_TIMER, 7'd55, 16'd77, 16'd1));
        queue_cmd(make_cmd(mesch_pkg::OP_TIMER, mesch_pkg::EK_CTRL, 7'd0, 16'hFFFF, 16'd0));
        queue_cmd(make_cmd(mesch_pkg::OP_NONE, mesch_pkg::EK_TIMER, 7'h7F, 16'hFFFF,
                           16'hFFFF));
        queue_cmd(make_cmd(mesch_pkg::OP_ADVANCE, mesch_pkg::EK_NOTE_ON, 7'd0, 16'd0, 16'd0));
        queue_cmd(make_cmd(mesch_pkg::OP_ADVANCE, mesch_pkg::EK_NOTE_ON, 7'd0, 16'd0, 16'd5));
        queue_cmd(make_cmd(mesch_pkg::OP_INSERT, mesch_pkg::EK_NOTE_OFF, 7'd127, 16'd4,
                           16'hFFFF));
        queue_cmd(make_cmd(mesch_pkg::OP_INSERT, mesch_pkg::EK_NOTE_OFF, 7'd127, 16'd4,
                           16'hFFFF));
        queue_cmd(make_cmd(mesch_pkg::OP_ADVANCE, mesch_pkg::EK_NOTE_ON, 7'd0, 16'd0,
                           16'hFFFF));
        // Fill the queue past its depth, then drain everything at once.
        repeat (mesch_pkg::QUEUE_DEPTH + 2)
        begin
            queue_cmd(make_cmd(mesch_pkg::OP_TIMER, mesch_pkg::EK_NOTE_ON, 7'd0,
                               16'($urandom), 16'($urandom_range(0, 3))));
        end
        queue_cmd(make_cmd(mesch_pkg::OP_INSERT, mesch_pkg::EK_NOTE_ON, 7'd1, 16'd1, 16'd1));
        queue_cmd(make_cmd(mesch_pkg::OP_ADVANCE, mesch_pkg::EK_NOTE_ON, 7'd0, 16'd0, 16'd10));
        // Sender pauses until every expected result has come.
        wait_idle();

        add_random(20);
        wait_idle();

        // Bypass phase: inserts still work, advances stand still.
        write_bypass(1'b1);
        queue_cmd(make_cmd(mesch_pkg::OP_INSERT, mesch_pkg::EK_CTRL, 7'd9, 16'd3, 16'd0));
        queue_cmd(make_cmd(mesch_pkg::OP_ADVANCE, mesch_pkg::EK_NOTE_ON, 7'd0, 16'd0,
                           16'hFFFF));
        add_random(10);
        wait_idle();

        write_bypass(1'b0);
        add_random(35);
        wait_idle();

        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
